// File: design/srfp_pkg.sv
// Shared constants and types for the servo reply frame parser.
package srfp_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    // Header bytes.
    localparam logic [7:0] HDR_FIRST  = 8'hFF;
    localparam logic [7:0] HDR_SECOND = 8'hF5;

    // Positions of the payload bytes within the frame.
    localparam logic [IDX_W-1:0] IDX_ID     = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_POS_HI = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_POS_LO = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_CHECK  = IDX_W'(FRAME_BYTES - 1);

    // Parser phase codes.
    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_GOT_FF = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    // Collected frame body, ahead of the checksum byte.
    typedef struct packed {
        logic [7:0] servo_id;
        logic [7:0] sum;
        logic [7:0] pos_hi;
        logic [7:0] pos_lo;
    } body_t;

    // Decoded reply.
    typedef struct packed {
        logic [7:0]  servo_id;
        logic        checksum_ok;
        logic [15:0] position;
    } reply_t;

endpackage

// File: design/srfp_frame_eval.sv
// Checksum check and reply decode for a completed frame.
module srfp_frame_eval (
    input  srfp_pkg::body_t  body,
    input  logic [7:0]       check_byte,
    output srfp_pkg::reply_t reply
);
    import srfp_pkg::*;

    logic ok;

    // Checksum is the inverted 8-bit sum of the id through position bytes.
    assign ok = (~body.sum == check_byte);

    always_comb begin
        reply.servo_id    = body.servo_id;
        reply.checksum_ok = ok;
        reply.position    = ok ? {body.pos_hi, body.pos_lo} : 16'd0;
    end

endmodule

// File: design/servo_reply_frame_parser.sv
// Top level of the servo reply frame parser: byte hunting, body capture, result register.
//
// Servo reply frame parser. Each accepted word on the s_ channel is one byte
// from the servo bus UART. The block hunts for the header 0xFF 0xF5 (a lone
// 0xF5 while hunting also counts as a full header); a byte other than 0xF5
// right after 0xFF drops the parser back to hunting and is discarded. The six
// bytes after the header are the body: servo id, two more bytes, position high,
// position low, and a checksum byte. When the checksum byte arrives, one word
// goes out on the m_ channel with the id, a checksum-ok flag and the
// big-endian position (zero when the checksum fails). Rate: one input word per
// clock, sustained while no reply waits on a low m_ready. Each byte is handled
// in the cycle it is accepted by a running 8-bit sum and a few captured bytes,
// so nothing is buffered beyond the frame itself; the reply is in the output
// register in the cycle after the checksum byte is accepted. s_ready drops only
// while a reply waits in the output register and m_ready is low.
module servo_reply_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_servo_id,
    output logic        m_checksum_ok,
    output logic [15:0] m_position
);
    import srfp_pkg::*;

    logic [1:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    body_t            body_reg, body_next;
    logic             m_valid_reg, m_valid_next;
    reply_t           reply_reg, reply_next;
    reply_t           reply_eval;
    logic             accept;
    logic             emit;

    // Take a new word whenever the output register is free or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    srfp_frame_eval u_eval (
        .body       (body_reg),
        .check_byte (s_rx_byte),
        .reply      (reply_eval)
    );

    // Parser state update for one accepted byte.
    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        body_next  = body_reg;
        emit       = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (s_rx_byte == HDR_FIRST) begin
                        phase_next = PH_GOT_FF;
                    end else if (s_rx_byte == HDR_SECOND) begin
                        // Lone 0xF5 stands for the full header.
                        phase_next    = PH_BODY;
                        idx_next      = IDX_ID;
                        body_next.sum = 8'd0;
                    end
                end
                PH_GOT_FF: begin
                    if (s_rx_byte == HDR_SECOND) begin
                        phase_next    = PH_BODY;
                        idx_next      = IDX_ID;
                        body_next.sum = 8'd0;
                    end else begin
                        // Drop the byte, even another 0xFF.
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    if (idx_reg == IDX_CHECK) begin
                        emit       = 1'b1;
                        phase_next = PH_HUNT;
                    end else begin
                        body_next.sum = body_reg.sum + s_rx_byte;
                        idx_next      = idx_reg + IDX_W'(1);
                        if (idx_reg == IDX_ID) begin
                            body_next.servo_id = s_rx_byte;
                        end
                        if (idx_reg == IDX_POS_HI) begin
                            body_next.pos_hi = s_rx_byte;
                        end
                        if (idx_reg == IDX_POS_LO) begin
                            body_next.pos_lo = s_rx_byte;
                        end
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Output register: load on a completed frame, clear when drained.
    always_comb begin
        m_valid_next = m_valid_reg;
        reply_next   = reply_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            reply_next   = reply_eval;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        body_reg  <= body_next;
        reply_reg <= reply_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_servo_id    = reply_reg.servo_id;
    assign m_checksum_ok = reply_reg.checksum_ok;
    assign m_position    = reply_reg.position;

endmodule
